FILE: sv/wlcs_pkg.sv
// shared types, constants and codes for the wear levelled counter slot unit
`timescale 1ns / 1ps
`default_nettype none
package wlcs_pkg;

  // ring geometry
  localparam int unsigned SLOTS = 8;
  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SLOT_FIELD_W = 3;

  // erased slot pattern and register reset
  localparam logic [VALUE_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] WRITE_LIMIT_RESET = 16'd1000;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // operation codes
  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_WRITTEN = 2'd0,
    ST_PRESENT = 2'd1,
    ST_BUDGET  = 2'd2,
    ST_READ    = 2'd3
  } status_e;

  // input word
  typedef struct packed {
    func_e              func;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [VALUE_W-1:0]      result_value;
    logic [SLOT_FIELD_W-1:0] slot_index;
    status_e                 status;
    logic [COUNT_W-1:0]      writes_used;
  } out_word_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic write_back;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic budget_spent;
    logic is_read;
    logic scan_last;
    logic found;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: sv/wlcs_datapath.sv
// datapath: slot registers, scan comparator, write counter and result forming
`timescale 1ns / 1ps
`default_nettype none
module wlcs_datapath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire wlcs_pkg::in_word_t        cmd_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [15:0]               cfg_wdata_i,
  input  wire wlcs_pkg::dp_cmd_t         dp_cmd_i,
  output wlcs_pkg::dp_stat_t             dp_stat_o,
  output wlcs_pkg::out_word_t            result_o
);
  import wlcs_pkg::*;

  logic [VALUE_W-1:0] slot_q [SLOTS];
  logic [COUNT_W-1:0] limit_q;
  logic [COUNT_W-1:0] wcount_q;
  func_e              func_q;
  logic [VALUE_W-1:0] value_q;
  logic               budget_q;
  logic [VALUE_W-1:0] best_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic               found_q;
  logic [IDX_W-1:0]   match_idx_q;
  logic [IDX_W-1:0]   cnt_q;

  logic [VALUE_W-1:0] slot_rd;
  logic [VALUE_W-1:0] slot_val;
  logic [IDX_W-1:0]   wr_idx;
  logic               hit_now;
  logic               better_now;

  // current slot under the scan, erased reads as zero
  assign slot_rd    = slot_q[cnt_q];
  assign slot_val   = (slot_rd == ERASED_WORD) ? '0 : slot_rd;
  assign hit_now    = !found_q && (slot_val == value_q);
  assign better_now = slot_val > best_q;

  // slot after the first largest one, wrapping round the ring
  assign wr_idx = (best_idx_q == IDX_W'(SLOTS - 1)) ? '0 : best_idx_q + IDX_W'(1);

  // status towards the controller
  assign dp_stat_o.budget_spent = (cmd_i.func == FUNC_STORE) && (wcount_q >= limit_q);
  assign dp_stat_o.is_read      = (func_q == FUNC_READ);
  assign dp_stat_o.scan_last    = (cnt_q == IDX_W'(SLOTS - 1));
  assign dp_stat_o.found        = found_q || hit_now;

  // limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= WRITE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // slot ring and write counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_q[i] <= ERASED_WORD;
      end
      wcount_q <= '0;
    end else if (dp_cmd_i.write_back) begin
      slot_q[wr_idx] <= value_q;
      if (wcount_q != COUNT_MAX) begin
        wcount_q <= wcount_q + COUNT_W'(1);
      end
    end
  end

  // word capture and scan tracking
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      func_q      <= cmd_i.func;
      value_q     <= cmd_i.value;
      budget_q    <= dp_stat_o.budget_spent;
      best_q      <= '0;
      best_idx_q  <= '0;
      found_q     <= 1'b0;
      match_idx_q <= '0;
      cnt_q       <= '0;
    end else if (dp_cmd_i.scan) begin
      if (better_now) begin
        best_q     <= slot_val;
        best_idx_q <= cnt_q;
      end
      if (hit_now) begin
        found_q     <= 1'b1;
        match_idx_q <= cnt_q;
      end
      if (!dp_stat_o.scan_last) begin
        cnt_q <= cnt_q + IDX_W'(1);
      end
    end
  end

  // result word from the held scan outcome
  always_comb begin
    result_o.writes_used = wcount_q;
    if (func_q == FUNC_READ) begin
      result_o.result_value = best_q;
      result_o.slot_index   = SLOT_FIELD_W'(best_idx_q);
      result_o.status       = ST_READ;
    end else if (budget_q) begin
      result_o.result_value = value_q;
      result_o.slot_index   = '0;
      result_o.status       = ST_BUDGET;
    end else if (found_q) begin
      result_o.result_value = value_q;
      result_o.slot_index   = SLOT_FIELD_W'(match_idx_q);
      result_o.status       = ST_PRESENT;
    end else begin
      result_o.result_value = value_q;
      result_o.slot_index   = SLOT_FIELD_W'(wr_idx);
      result_o.status       = ST_WRITTEN;
    end
  end

endmodule
`default_nettype wire

FILE: sv/wlcs_ctrl.sv
// controller: sequences capture, slot scan, write-back and result strobe
`timescale 1ns / 1ps
`default_nettype none
module wlcs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  output logic                    done_o,
  input  wire wlcs_pkg::dp_stat_t dp_stat_i,
  output wlcs_pkg::dp_cmd_t       dp_cmd_o
);
  import wlcs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  // commands to the datapath
  assign dp_cmd_o.load       = accept;
  assign dp_cmd_o.scan       = (state_q == S_SCAN);
  assign dp_cmd_o.write_back = (state_q == S_WRITE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = dp_stat_i.budget_spent ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (dp_stat_i.scan_last) begin
          if (dp_stat_i.is_read || dp_stat_i.found) begin
            state_d = S_DONE;
          end else begin
            state_d = S_WRITE;
          end
        end
      end
      S_WRITE: state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // checks
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy) else $error("not busy after taking a word");
  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.write_back |-> $past(!dp_stat_i.found && !dp_stat_i.is_read))
    else $error("write-back after a hit or on a read");
  a_write_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.write_back |=> done_o) else $error("write-back not followed by result");

endmodule
`default_nettype wire

FILE: sv/wear_leveled_counter_slots_unit.sv
// top level of the wear levelled counter slot unit
//
// Usage: raise start with a word on cmd_i while busy is low; the word is
// taken at that clock edge and busy rises on the next cycle. func store
// looks for the value in the slot ring and, if absent, writes it into the
// slot after the first largest one; func read returns the largest slot.
// Each word gives exactly one result word on result_o, marked by done_o
// for a single cycle; the receiver cannot hold it off and must take it.
// The result is taken at the edge that ends the done_o cycle. A store
// refused for a spent budget skips the scan; other words scan SLOTS
// slots, one per cycle through the one slot read port, and a store that
// writes adds a write-back step after the scan. busy falls in the cycle
// after done_o, and the next word can be taken only once busy is low.
// The write limit is loaded through cfg_we_i / cfg_wdata_i; the user must
// load it only while idle, as the block itself does not enforce this.
// Reset: all slots erased (all ones), write count zero, limit 1000; no
// clearing pass is needed, the block is ready straight after reset.
`timescale 1ns / 1ps
`default_nettype none
module wear_leveled_counter_slots_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire wlcs_pkg::in_word_t  cmd_i,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  output logic                     done_o,
  output wlcs_pkg::out_word_t      result_o
);
  import wlcs_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer
  wlcs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .done_o    (done_o),
    .dp_stat_i (dp_stat),
    .dp_cmd_o  (dp_cmd)
  );

  // slot ring and result datapath
  wlcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .dp_cmd_i    (dp_cmd),
    .dp_stat_o   (dp_stat),
    .result_o    (result_o)
  );

endmodule
`default_nettype wire

FILE: bench/wlcs_result_checker.sv
// result checker for the wear levelled counter slot unit: predicts and compares each word
`timescale 1ns / 1ps
module wlcs_result_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic                busy_i,
  input  wire wlcs_pkg::in_word_t  cmd_i,
  input  wire logic                cfg_we_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                done_i,
  input  wire wlcs_pkg::out_word_t result_i,
  output int                       fail_count_o,
  output int                       outstanding_o,
  output int                       words_checked_o
);
  import wlcs_pkg::*;

  // shadow copy of the slot ring, write counter and limit
  logic [VALUE_W-1:0] slot_img [SLOTS];
  logic [COUNT_W-1:0] writes_done;
  logic [COUNT_W-1:0] limit_reg;
  out_word_t          expected_words [$];

  initial begin
    fail_count_o    = 0;
    words_checked_o = 0;
    outstanding_o   = 0;
  end

  // an erased slot counts as zero
  function automatic logic [VALUE_W-1:0] counted(int unsigned i);
    return (slot_img[i] == ERASED_WORD) ? '0 : slot_img[i];
  endfunction

  // first slot holding the largest counted value, slot 0 when all are zero
  function automatic int unsigned largest_at(output logic [VALUE_W-1:0] best);
    int unsigned at;
    best = '0;
    at   = 0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (counted(i) > best) begin
        best = counted(i);
        at   = i;
      end
    end
    return at;
  endfunction

  // outcome of one word on the shadow ring, updating it on a write
  function automatic out_word_t slot_ring_outcome(in_word_t w);
    out_word_t          r;
    logic [VALUE_W-1:0] best;
    int unsigned        at;
    bit                 hit;
    r.result_value = w.value;
    hit = 1'b0;
    at  = 0;
    if (w.func == FUNC_READ) begin
      at = largest_at(best);
      r.result_value = best;
      r.status = ST_READ;
    end else if (writes_done >= limit_reg) begin
      // refused before the scan, even when the value is already present
      r.status = ST_BUDGET;
    end else begin
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (!hit && counted(i) == w.value) begin
          hit = 1'b1;
          at  = i;
        end
      end
      if (hit) begin
        r.status = ST_PRESENT;
      end else begin
        // slot after the first largest one, wrapping round the ring
        at = largest_at(best) + 1;
        if (at >= SLOTS) at = 0;
        slot_img[at] = w.value;
        if (writes_done != COUNT_MAX) writes_done = writes_done + 1'b1;
        r.status = ST_WRITTEN;
      end
    end
    r.slot_index  = at[SLOT_FIELD_W-1:0];
    r.writes_used = writes_done;
    return r;
  endfunction

  // one line per mismatch, and count it
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] seen);
    fail_count_o++;
    $display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, seen);
  endtask

  // watch the handshakes at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t want;
    if (!rst_ni) begin
      for (int unsigned i = 0; i < SLOTS; i++) slot_img[i] = ERASED_WORD;
      writes_done = '0;
      limit_reg   = WRITE_LIMIT_RESET;
      expected_words.delete();
      outstanding_o <= 0;
    end else begin
      // result word against the oldest expectation
      if (done_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", '0, result_i.result_value);
        end else begin
          want = expected_words.pop_front();
          words_checked_o++;
          if (result_i.result_value !== want.result_value)
            report_mismatch("result_value", want.result_value, result_i.result_value);
          if (result_i.slot_index !== want.slot_index)
            report_mismatch("slot_index", want.slot_index, result_i.slot_index);
          if (result_i.status !== want.status)
            report_mismatch("status", want.status, result_i.status);
          if (result_i.writes_used !== want.writes_used)
            report_mismatch("writes_used", want.writes_used, result_i.writes_used);
        end
      end
      // accepted word sees the limit held before this edge
      if (start_i && !busy_i) expected_words.push_back(slot_ring_outcome(cmd_i));
      // limit register write
      if (cfg_we_i) limit_reg = cfg_wdata_i;
      outstanding_o <= expected_words.size();
    end
  end

endmodule

FILE: bench/wear_leveled_counter_slots_unit_test.sv
// testbench top for the wear levelled counter slot unit: stimulus and verdict
`timescale 1ns / 1ps
module wear_leveled_counter_slots_unit_test;
  import wlcs_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  in_word_t    cmd_i       = '0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        busy;
  logic        done_o;
  out_word_t   result_o;

  int fail_count;
  int outstanding;
  int words_checked;

  // stimulus state: running counter, recent stores and idle bursts
  logic [31:0] counter_val;
  logic [31:0] recent_vals [8];
  int          recent_at;
  int          burst_left;
  int          phases_run;

  always #5 clk_i = ~clk_i;

  wear_leveled_counter_slots_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  wlcs_result_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .cmd_i           (cmd_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_i          (done_o),
    .result_i        (result_o),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .words_checked_o (words_checked)
  );

  // offer one word after a random gap, return once it is taken
  task automatic send_word(func_e f, logic [31:0] v);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(5, 20);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= '{func: f, value: v};
    do @(posedge clk_i); while (busy);
    if (f == FUNC_STORE) begin
      recent_vals[recent_at] = v;
      recent_at = (recent_at + 1) % 8;
    end
  endtask

  // stop sending and wait for every expected word, then let the unit settle
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // limit register write, only called while idle
  task automatic set_write_limit(logic [15:0] lim);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lim;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly a rising counter, with repeats, reads and odd values mixed in
  task automatic send_random_word;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_word(FUNC_READ, $urandom);
    end else if (pick < 62) begin
      counter_val = counter_val + $urandom_range(1, 40);
      send_word(FUNC_STORE, counter_val);
    end else if (pick < 74) begin
      send_word(FUNC_STORE, recent_vals[$urandom_range(0, 7)]);
    end else if (pick < 80) begin
      send_word(FUNC_STORE, counter_val - $urandom_range(0, 3));
    end else if (pick < 88) begin
      case ($urandom_range(0, 4))
        0:       send_word(FUNC_STORE, 32'h0000_0000);
        1:       send_word(FUNC_STORE, ERASED_WORD);
        2:       send_word(FUNC_STORE, 32'hFFFF_FFFE);
        3:       send_word(FUNC_STORE, 32'h8000_0000);
        default: send_word(FUNC_STORE, 32'h0000_0001);
      endcase
    end else begin
      send_word(FUNC_STORE, $urandom);
    end
  endtask

  // one limit setting followed by a run of random words
  task automatic run_phase(int n, logic [15:0] lim, logic [31:0] counter_base);
    drain();
    set_write_limit(lim);
    counter_val = counter_base;
    phases_run++;
    repeat (n) send_random_word();
  endtask

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d words still expected", outstanding);
    $display("wear_leveled_counter_slots_unit verification failed");
    $finish;
  end

  initial begin
    recent_at  = 0;
    burst_left = 0;
    phases_run = 0;
    for (int i = 0; i < 8; i++) recent_vals[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, zero and all-ones stores, ramp past the ring end
    send_word(FUNC_READ, 32'hFFFF_FFFF);
    send_word(FUNC_STORE, 32'h0000_0000);
    send_word(FUNC_STORE, ERASED_WORD);
    send_word(FUNC_READ, 32'h0000_0000);
    for (int v = 1; v <= 9; v++) send_word(FUNC_STORE, v);
    send_word(FUNC_STORE, ERASED_WORD);
    send_word(FUNC_STORE, 32'h0000_0000);
    send_word(FUNC_STORE, 32'hFFFF_FFFE);
    send_word(FUNC_STORE, 32'h0000_0005);
    send_word(FUNC_READ, 32'h5A5A_5A5A);
    send_word(FUNC_STORE, 32'hFFFF_FFFE);

    // directed: spent budget, including a value that is already present
    drain();
    set_write_limit(16'd0);
    send_word(FUNC_STORE, 32'h0000_0005);
    send_word(FUNC_STORE, 32'h0000_0000);
    send_word(FUNC_READ, 32'h0000_0000);

    // random phases across the limit range
    run_phase(150, 16'hFFFF, 32'h0000_0010);
    run_phase(30, 16'd0, 32'h1234_0000);
    run_phase(150, 16'($urandom_range(50, 250)), 32'hFFFF_FF00);
    run_phase(40, 16'd1, 32'h0000_0100);
    run_phase(80, 16'hFFFF, $urandom);

    drain();
    repeat (16) @(posedge clk_i);
    $display("checked %0d result words over %0d random limit settings plus directed words",
             words_checked, phases_run);
    $display("covered reads, stores present and written, refused budget and ring wrap");
    if (fail_count == 0) begin
      $display("wear_leveled_counter_slots_unit verification clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("wear_leveled_counter_slots_unit verification failed");
    end
    $finish;
  end

endmodule
